FILE: rtl/core/mkpc_pkg.sv
// shared types, constants and codes of the multi-key press classifier
`timescale 1ns / 1ps

package mkpc_pkg;

  localparam int NUM_KEYS = 4;
  localparam int LEVEL_W  = 4;
  localparam int INDEX_W  = 2;
  localparam int FLAG_W   = 7;
  localparam int TIMER_W  = 16;
  localparam int PERIOD_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  typedef logic [FLAG_W-1:0]  flags_t;
  typedef logic [TIMER_W-1:0] timer_t;

  localparam int F_HOLD   = 0;
  localparam int F_DOWN   = 1;
  localparam int F_UP     = 2;
  localparam int F_SINGLE = 3;
  localparam int F_DOUBLE = 4;
  localparam int F_LONG   = 5;
  localparam int F_REPEAT = 6;

  localparam flags_t HOLD_MASK = flags_t'(1) << F_HOLD;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_CHECK     = 2'd1,
    OP_CLEAR_ONE = 2'd2,
    OP_CLEAR_ALL = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_PERIOD = 2'd0,
    REG_LONG_PRESS  = 2'd1,
    REG_DOUBLE_GAP  = 2'd2,
    REG_REPEAT      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic   tick;
    logic   sample;
    logic   check;
    logic   clear_one;
    logic   clear_all;
    flags_t mask;
    timer_t long_ticks;
    timer_t gap_ticks;
    timer_t repeat_ticks;
  } lane_ctl_t;

endpackage

FILE: rtl/core/mkpc_lane.sv
// per-key lane: level edge flags, press phase machine and countdown timer
`timescale 1ns / 1ps

module mkpc_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  mkpc_pkg::lane_ctl_t ctl,
  input  logic                sel,
  input  logic                level,
  output mkpc_pkg::flags_t    flags
);
  import mkpc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESSED  = 3'd1,
    PH_RELEASED = 3'd2,
    PH_SECOND   = 3'd3,
    PH_LONG     = 3'd4
  } phase_t;

  phase_t phase_r, phase_nxt;
  timer_t timer_r, timer_nxt;
  logic   level_r, level_nxt;
  flags_t flags_r, flags_nxt;
  timer_t timer_dec;

  always_comb begin
    timer_dec = (ctl.tick && timer_r != '0) ? timer_r - timer_t'(1) : timer_r;
    phase_nxt = phase_r;
    timer_nxt = timer_dec;
    level_nxt = level_r;
    flags_nxt = flags_r;
    if (ctl.sample) begin
      level_nxt = level;
      flags_nxt[F_HOLD] = level;
      if (level && !level_r) begin
        flags_nxt[F_DOWN] = 1'b1;
      end else if (!level && level_r) begin
        flags_nxt[F_UP] = 1'b1;
      end
      unique case (phase_r)
        PH_PRESSED: begin
          if (!level) begin
            timer_nxt = ctl.gap_ticks;
            phase_nxt = PH_RELEASED;
          end else if (timer_dec == '0) begin
            flags_nxt[F_LONG] = 1'b1;
            timer_nxt = ctl.repeat_ticks;
            phase_nxt = PH_LONG;
          end
        end
        PH_RELEASED: begin
          if (level) begin
            flags_nxt[F_DOUBLE] = 1'b1;
            phase_nxt = PH_SECOND;
          end else if (timer_dec == '0) begin
            flags_nxt[F_SINGLE] = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_SECOND: begin
          if (!level) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_LONG: begin
          if (!level) begin
            timer_nxt = '0;
            phase_nxt = PH_IDLE;
          end else if (timer_dec == '0) begin
            flags_nxt[F_REPEAT] = 1'b1;
            timer_nxt = ctl.repeat_ticks;
          end
        end
        default: begin
          if (level) begin
            timer_nxt = ctl.long_ticks;
            phase_nxt = PH_PRESSED;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      endcase
    end
    if (ctl.check && sel && (flags_r & ctl.mask) != '0) begin
      flags_nxt = flags_r & ~(ctl.mask & ~HOLD_MASK);
    end
    if (ctl.clear_all || (ctl.clear_one && sel)) begin
      flags_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      level_r <= 1'b0;
      flags_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      level_r <= level_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign flags = flags_r;

endmodule

FILE: rtl/core/mkpc_merge.sv
// merge stage: picks the addressed lane's flags, forms the hit and holds results
`timescale 1ns / 1ps

module mkpc_merge (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        accept,
  input  logic                                        check,
  input  logic [mkpc_pkg::NUM_KEYS-1:0]               sel,
  input  mkpc_pkg::flags_t                            mask,
  input  mkpc_pkg::flags_t [mkpc_pkg::NUM_KEYS-1:0]   lane_flags,
  output logic                                        in_ready,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [mkpc_pkg::OUT_TDATA_W-1:0]            out_tdata
);
  import mkpc_pkg::*;

  flags_t                 picked;
  logic [OUT_TDATA_W-1:0] result;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_TDATA_W-1:0] skid_data_r, skid_data_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  logic                   pop;

  always_comb begin
    picked = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (sel[k]) begin
        picked = picked | lane_flags[k];
      end
    end
    if (check) begin
      result = {picked, (picked & mask) != '0};
    end else begin
      result = '0;
    end
  end

  assign pop = out_valid_r && out_tready;

  always_comb begin
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_valid_nxt = skid_valid_r;
    if (accept) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = result;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = result;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_ready   = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a full skid stage always sits behind a full output stage
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds data with output stage empty");

  // items other than check answer with zeros
  a_noncheck_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !check && (!out_valid_r || pop)) |=> (out_data_r == '0))
    else $error("non-check item gave a nonzero result");

  // a hit needs at least one flag set
  a_hit_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[0]) |-> (out_data_r[OUT_TDATA_W-1:1] != '0))
    else $error("hit reported with no flags");

  // no transfer while the skid stage is full
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !accept)
    else $error("item taken with skid stage full");

endmodule

FILE: rtl/core/multi_key_press_classifier_top.sv
// top level of the multi-key press classifier: config, scan divider, lanes, merge
`timescale 1ns / 1ps

//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   tuser operation, tdata key fields
//  out_     out  out_tvalid/out_tready tdata flag_hit, key_flags_now
//  cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  one item per cycle while in_tready is high; each key lane updates in the cycle of the transfer
//  results are registered in an output stage, or in a skid stage while the output stage is full
//  in_tready drops only while both result stages are full
//  reset is synchronous, all key state and the scan divider clear at once
//  cfg_ready is always high

module multi_key_press_classifier_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] operation
  input  logic [1:0]                          in_tuser,
  // [3:0] key_pressed, [5:4] key_index, [12:6] flag_mask, [15:13] zero
  input  logic [mkpc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] flag_hit, [7:1] key_flags_now
  output logic [mkpc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mkpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mkpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mkpc_pkg::*;

  logic [PERIOD_W-1:0] scan_period_r;
  timer_t              long_ticks_r;
  timer_t              gap_ticks_r;
  timer_t              repeat_ticks_r;
  logic [PERIOD_W-1:0] div_r, div_nxt, div_inc;

  op_t                 op;
  logic [LEVEL_W-1:0]  key_pressed;
  logic [INDEX_W-1:0]  key_index;
  flags_t              flag_mask;
  logic                accept;
  logic                sample;
  logic [NUM_KEYS-1:0] sel;
  lane_ctl_t           ctl;
  flags_t [NUM_KEYS-1:0] lane_flags;

  assign op          = op_t'(in_tuser);
  assign key_pressed = in_tdata[LEVEL_W-1:0];
  assign key_index   = in_tdata[LEVEL_W +: INDEX_W];
  assign flag_mask   = in_tdata[LEVEL_W+INDEX_W +: FLAG_W];
  assign accept      = in_tvalid && in_tready;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_period_r  <= PERIOD_W'(10);
      long_ticks_r   <= timer_t'(1000);
      gap_ticks_r    <= timer_t'(300);
      repeat_ticks_r <= timer_t'(200);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SCAN_PERIOD: scan_period_r  <= cfg_data[PERIOD_W-1:0];
        REG_LONG_PRESS:  long_ticks_r   <= cfg_data[TIMER_W-1:0];
        REG_DOUBLE_GAP:  gap_ticks_r    <= cfg_data[TIMER_W-1:0];
        REG_REPEAT:      repeat_ticks_r <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    div_inc = div_r + PERIOD_W'(1);
    sample  = accept && (op == OP_TICK) && (div_inc >= scan_period_r);
    div_nxt = div_r;
    if (accept && op == OP_TICK) begin
      div_nxt = sample ? '0 : div_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
    end else begin
      div_r <= div_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      sel[k] = (int'(key_index) == k);
    end
  end

  always_comb begin
    ctl.tick         = accept && (op == OP_TICK);
    ctl.sample       = sample;
    ctl.check        = accept && (op == OP_CHECK);
    ctl.clear_one    = accept && (op == OP_CLEAR_ONE);
    ctl.clear_all    = accept && (op == OP_CLEAR_ALL);
    ctl.mask         = flag_mask;
    ctl.long_ticks   = long_ticks_r;
    ctl.gap_ticks    = gap_ticks_r;
    ctl.repeat_ticks = repeat_ticks_r;
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic lvl;
    if (k < LEVEL_W) begin : g_pin
      assign lvl = key_pressed[k];
    end else begin : g_none
      assign lvl = 1'b0;
    end
    mkpc_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .sel   (sel[k]),
      .level (lvl),
      .flags (lane_flags[k])
    );
  end

  mkpc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .check      (op == OP_CHECK),
    .sel        (sel),
    .mask       (flag_mask),
    .lane_flags (lane_flags),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
